[src/obuhp_pkg.sv]
package obuhp_pkg;

	// Result codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BAD_TYPE = 3'd2,
		ST_NO_EXT   = 3'd3,
		ST_TRUNC    = 3'd4,
		ST_OVERFLOW = 3'd5,
		ST_TOO_BIG  = 3'd6
	} status_t;

	// Parser phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_EXT  = 2'd1,
		PH_SIZE = 2'd2
	} phase_t;

	localparam int unsigned LEN_W   = 32;
	localparam int unsigned GROUP_W = 7;
	localparam logic [3:0] TYPE_RESERVED_HI = 4'd15;
	localparam logic [3:0] TYPE_LAST_PLAIN  = 4'd8;

	// One decoded header, as it leaves the parser
	typedef struct packed {
		status_t          status;
		logic [3:0]       obu_kind;
		logic             has_extension;
		logic [2:0]       tlayer_id;
		logic [1:0]       slayer_id;
		logic [3:0]       header_length;
		logic [LEN_W-1:0] payload_size;
	} result_t;

	// Types 1 to 8 and 15 are accepted
	function automatic logic type_ok(input logic [3:0] t);
		return ((t != 4'd0) && (t <= TYPE_LAST_PLAIN)) || (t == TYPE_RESERVED_HI);
	endfunction

endpackage

[src/obuhp_core.sv]
module obuhp_core
	import obuhp_pkg::*;
#(
	parameter int unsigned MAX_SIZE_BYTES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	input  logic             start_req,
	input  logic [LEN_W-1:0] buffer_length,
	output logic             res_valid,
	output result_t          res
);

	localparam int unsigned IDX_W = $clog2(MAX_SIZE_BYTES + 3);
	localparam int unsigned CNT_W = $clog2(MAX_SIZE_BYTES + 1);
	localparam int unsigned GI_W  = $clog2(MAX_SIZE_BYTES);
	localparam int unsigned ACC_W = GROUP_W * MAX_SIZE_BYTES;

	phase_t                                 phase_q, phase_n;
	logic [LEN_W-1:0]                       total_q, total_n;
	logic [IDX_W-1:0]                       idx_q, idx_n;
	logic [CNT_W-1:0]                       cnt_q, cnt_n;
	logic [MAX_SIZE_BYTES-1:0][GROUP_W-1:0] acc_q, acc_n;
	logic [3:0]                             type_q, type_n;
	logic                                   ext_q, ext_n;
	logic                                   sflag_q, sflag_n;
	logic [2:0]                             tid_q, tid_n;
	logic [1:0]                             sid_q, sid_n;

	logic                                   fixed_done;
	logic [LEN_W-1:0]                       idx_ext;
	logic [ACC_W-1:0]                       size_val;
	logic [LEN_W-1:0]                       room;
	logic                                   size_big;
	status_t                                st;
	logic [3:0]                             hlen;
	logic [LEN_W-1:0]                       psize;

	assign idx_ext  = LEN_W'(idx_n);
	assign room     = total_n - idx_ext;
	assign size_val = acc_n;
	assign size_big = (|size_val[ACC_W-1:LEN_W]) || (&size_val[LEN_W-1:0]);

	// Next state and result for the current word
	always_comb begin
		phase_n    = phase_q;
		total_n    = total_q;
		idx_n      = idx_q;
		cnt_n      = cnt_q;
		acc_n      = acc_q;
		type_n     = type_q;
		ext_n      = ext_q;
		sflag_n    = sflag_q;
		tid_n      = tid_q;
		sid_n      = sid_q;
		res_valid  = 1'b0;
		st         = ST_OK;
		hlen       = '0;
		psize      = '0;
		fixed_done = 1'b0;

		if (start_req) begin
			// restart on a new buffer, abandoning any parse in flight
			total_n = buffer_length;
			idx_n   = '0;
			cnt_n   = '0;
			acc_n   = '0;
			type_n  = '0;
			ext_n   = 1'b0;
			sflag_n = 1'b0;
			tid_n   = '0;
			sid_n   = '0;
			if (buffer_length == '0) begin
				res_valid = 1'b1;
				st        = ST_EMPTY;
			end else begin
				type_n  = data_byte[6:3];
				ext_n   = data_byte[2];
				sflag_n = data_byte[1];
				idx_n   = IDX_W'(1);
				if (!type_ok(data_byte[6:3])) begin
					res_valid = 1'b1;
					st        = ST_BAD_TYPE;
				end else if (data_byte[2]) begin
					if (buffer_length < LEN_W'(2)) begin
						res_valid = 1'b1;
						st        = ST_NO_EXT;
					end else begin
						phase_n = PH_EXT;
					end
				end else begin
					fixed_done = 1'b1;
				end
			end
		end else begin
			unique case (phase_q)
				PH_EXT: begin
					tid_n      = data_byte[7:5];
					sid_n      = data_byte[4:3];
					idx_n      = idx_q + IDX_W'(1);
					fixed_done = 1'b1;
				end
				PH_SIZE: begin
					// shift in one seven-bit group, low group first
					acc_n[cnt_q[GI_W-1:0]] = data_byte[6:0];
					cnt_n = cnt_q + CNT_W'(1);
					idx_n = idx_q + IDX_W'(1);
					if (!data_byte[7] || (cnt_n >= CNT_W'(MAX_SIZE_BYTES))) begin
						res_valid = 1'b1;
						if (size_big) begin
							st = ST_OVERFLOW;
						end else if (size_val[LEN_W-1:0] > room) begin
							st = ST_TOO_BIG;
						end else begin
							st    = ST_OK;
							hlen  = 4'(idx_n);
							psize = size_val[LEN_W-1:0];
						end
					end else if (idx_ext >= total_n) begin
						res_valid = 1'b1;
						st        = ST_TRUNC;
					end
				end
				default: begin
				end
			endcase
		end

		// fixed header bytes done: finish or open the size field
		if (fixed_done) begin
			if (!sflag_n) begin
				res_valid = 1'b1;
				st        = ST_OK;
				hlen      = 4'(idx_n);
				psize     = room;
			end else if (idx_ext >= total_n) begin
				res_valid = 1'b1;
				st        = ST_TRUNC;
			end else begin
				acc_n   = '0;
				cnt_n   = '0;
				phase_n = PH_SIZE;
			end
		end

		if (res_valid) begin
			phase_n = PH_IDLE;
		end
	end

	// Pack the result
	always_comb begin
		res.status        = st;
		res.obu_kind      = type_n;
		res.has_extension = ext_n;
		res.tlayer_id     = tid_n;
		res.slayer_id     = sid_n;
		res.header_length = hlen;
		res.payload_size  = psize;
	end

	// Parser state, advanced once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			total_q <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			type_q  <= '0;
			ext_q   <= 1'b0;
			sflag_q <= 1'b0;
			tid_q   <= '0;
			sid_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			total_q <= total_n;
			idx_q   <= idx_n;
			cnt_q   <= cnt_n;
			acc_q   <= acc_n;
			type_q  <= type_n;
			ext_q   <= ext_n;
			sflag_q <= sflag_n;
			tid_q   <= tid_n;
			sid_q   <= sid_n;
		end
	end

endmodule

[src/av1_obu_header_parser_unit.sv]
// Channel | Signals                                   | Handshake
// input   | data_byte, start_req, buffer_length       | in_valid / in_stall
// output  | status, obu_kind, has_extension,          | out_valid / out_stall
//         | tlayer_id, slayer_id, header_length,      |
//         | payload_size                              |
//
// One word per cycle while neither side stalls; a taken word sits in the input
// register, and its result is loaded into the result register when it advances.
// The parser state is updated by one pass of logic per byte, between the
// input register and the result register.
// Reset is asynchronous, active low, and clears all control state.
// A stalled output holds its result; the input stalls only when the input
// register holds a word that would produce a result with the output full.
module av1_obu_header_parser_unit
	import obuhp_pkg::*;
#(
	parameter int unsigned MAX_SIZE_BYTES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             start_req,
	input  logic [LEN_W-1:0] buffer_length,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       status,
	output logic [3:0]       obu_kind,
	output logic             has_extension,
	output logic [2:0]       tlayer_id,
	output logic [1:0]       slayer_id,
	output logic [3:0]       header_length,
	output logic [LEN_W-1:0] payload_size
);

	logic             vld_s1;
	logic [7:0]       data_s1;
	logic             start_s1;
	logic [LEN_W-1:0] len_s1;
	logic             out_vld_q;
	result_t          out_q;
	logic             core_res_valid;
	result_t          core_res;
	logic             step;
	logic             in_take;

	// Advance the held word unless its result would overrun a stalled output
	assign step     = vld_s1 && (!core_res_valid || !out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !step;
	assign in_take  = in_valid && !in_stall;

	obuhp_core #(
		.MAX_SIZE_BYTES(MAX_SIZE_BYTES)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.data_byte    (data_s1),
		.start_req    (start_s1),
		.buffer_length(len_s1),
		.res_valid    (core_res_valid),
		.res          (core_res)
	);

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_take) begin
			vld_s1 <= 1'b1;
		end else if (step) begin
			vld_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1  <= data_byte;
			start_s1 <= start_req;
			len_s1   <= buffer_length;
		end
	end

	// Result register valid: load on a result, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (step && core_res_valid) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (step && core_res_valid) begin
			out_q <= core_res;
		end
	end

	assign out_valid     = out_vld_q;
	assign status        = out_q.status;
	assign obu_kind      = out_q.obu_kind;
	assign has_extension = out_q.has_extension;
	assign tlayer_id     = out_q.tlayer_id;
	assign slayer_id     = out_q.slayer_id;
	assign header_length = out_q.header_length;
	assign payload_size  = out_q.payload_size;

endmodule

[src/obuhp_checker.sv]
module obuhp_checker
	import obuhp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic [7:0]       data_byte,
	input logic             start_req,
	input logic [LEN_W-1:0] buffer_length,
	input logic             out_valid,
	input logic             out_stall,
	input logic [2:0]       status,
	input logic [3:0]       obu_kind,
	input logic             has_extension,
	input logic [2:0]       tlayer_id,
	input logic [1:0]       slayer_id,
	input logic [3:0]       header_length,
	input logic [LEN_W-1:0] payload_size
);

	// A stalled input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(data_byte) &&
		$stable(start_req) && $stable(buffer_length))
		else $error("input word changed while stalled");

	// A stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) &&
		$stable(header_length) && $stable(payload_size))
		else $error("output word changed while stalled");

	// Errors carry no length and no size
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (header_length == 4'd0) &&
		(payload_size == '0))
		else $error("error word carries length or size");

	// Good headers have a valid type and a sane length
	a_ok_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) |-> type_ok(obu_kind) &&
		(header_length != 4'd0) && (!has_extension || (header_length >= 4'd2)))
		else $error("good header word has bad type or length");

	// Ids stay zero without the extension byte
	a_no_ext_ids: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_extension |-> (tlayer_id == 3'd0) && (slayer_id == 2'd0))
		else $error("ids set without extension");

endmodule

bind av1_obu_header_parser_unit obuhp_checker u_obuhp_checker (.*);

[tb/testbench.sv]
module testbench;
	import obuhp_pkg::*;

	// OBU types used by the directed tests
	localparam logic [3:0] OBU_RESERVED_0 = 4'd0;
	localparam logic [3:0] OBU_SEQ_HDR    = 4'd1;
	localparam logic [3:0] OBU_TD         = 4'd2;
	localparam logic [3:0] OBU_FRAME      = 4'd6;
	localparam logic [3:0] OBU_RESERVED_9 = 4'd9;
	localparam logic [3:0] OBU_PADDING    = 4'd15;
	// one bit per type: 1 to 8 and 15 are legal
	localparam logic [15:0] LEGAL_TYPES     = 16'b1000_0001_1111_1110;
	localparam int          SIZE_GROUPS_MAX = 8;
	localparam int          CYCLE_LIMIT     = 200000;
	localparam logic        NEW_BUF         = 1'b1;
	localparam logic        SAME_BUF        = 1'b0;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [7:0]       data_byte;
	logic             start_req;
	logic [LEN_W-1:0] buffer_length;
	logic             out_valid;
	logic             out_stall;
	logic [2:0]       status;
	logic [3:0]       obu_kind;
	logic             has_extension;
	logic [2:0]       tlayer_id;
	logic [1:0]       slayer_id;
	logic [3:0]       header_length;
	logic [LEN_W-1:0] payload_size;

	av1_obu_header_parser_unit DUT (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Header decoder state, mirrored from the block
	phase_t      hdr_phase = PH_IDLE;
	logic [63:0] pos = '0;
	logic [63:0] buf_len = '0;
	logic [63:0] size_acc = '0;
	int unsigned size_cnt = 0;
	logic [3:0]  h_type = '0;
	logic        h_ext = 1'b0;
	logic        h_sflag = 1'b0;
	logic [2:0]  h_tid = '0;
	logic [1:0]  h_sid = '0;

	result_t expected_headers[$];
	int      mismatches = 0;
	int      sent_words = 0;
	int      cycles = 0;
	bit      tx_idle_en = 1'b1;
	bit      rx_idle_en = 1'b1;
	int      rx_hold = 0;

	function automatic logic [7:0] hdr_byte(logic [3:0] t, logic ext, logic sf);
		return {1'b0, t, ext, sf, 1'b0};
	endfunction

	// Queue one decoded header and return to idle
	function automatic void post_header(status_t st, logic [63:0] hlen, logic [63:0] psize);
		result_t r;
		r.status = st;
		r.obu_kind = h_type;
		r.has_extension = h_ext;
		r.tlayer_id = h_tid;
		r.slayer_id = h_sid;
		r.header_length = hlen[3:0];
		r.payload_size = psize[31:0];
		expected_headers.push_back(r);
		hdr_phase = PH_IDLE;
	endfunction

	// Fixed header bytes done: finish, or open the size field
	function automatic void finish_fixed();
		if (!h_sflag) begin
			post_header(ST_OK, pos, buf_len - pos);
		end else if (pos >= buf_len) begin
			post_header(ST_TRUNC, 0, 0);
		end else begin
			size_acc = '0;
			size_cnt = 0;
			hdr_phase = PH_SIZE;
		end
	endfunction

	// Advance the decoder by one word; return 1 if the word was parsed
	function automatic bit decode_obu_byte(logic [7:0] d, logic s, logic [31:0] len);
		logic [63:0] grp;
		if (s) begin
			buf_len = {32'b0, len};
			pos = '0;
			size_acc = '0;
			size_cnt = 0;
			h_type = '0;
			h_ext = 1'b0;
			h_sflag = 1'b0;
			h_tid = '0;
			h_sid = '0;
			if (len == 0) begin
				post_header(ST_EMPTY, 0, 0);
				return 1'b1;
			end
			h_type = d[6:3];
			h_ext = d[2];
			h_sflag = d[1];
			pos = 1;
			if (!LEGAL_TYPES[h_type]) begin
				post_header(ST_BAD_TYPE, 0, 0);
			end else if (h_ext) begin
				if (buf_len < 2)
					post_header(ST_NO_EXT, 0, 0);
				else
					hdr_phase = PH_EXT;
			end else begin
				finish_fixed();
			end
			return 1'b1;
		end
		case (hdr_phase)
			PH_EXT: begin
				h_tid = d[7:5];
				h_sid = d[4:3];
				pos = pos + 1;
				finish_fixed();
				return 1'b1;
			end
			PH_SIZE: begin
				grp = {57'b0, d[6:0]};
				size_acc = size_acc | (grp << (7 * (size_cnt % 8)));
				size_cnt = size_cnt + 1;
				pos = pos + 1;
				if (!d[7] || size_cnt >= SIZE_GROUPS_MAX) begin
					if (size_acc >= 64'hFFFF_FFFF)
						post_header(ST_OVERFLOW, 0, 0);
					else if (size_acc > buf_len - pos)
						post_header(ST_TOO_BIG, 0, 0);
					else
						post_header(ST_OK, pos, size_acc);
				end else if (pos >= buf_len) begin
					post_header(ST_TRUNC, 0, 0);
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Offer one word, with an optional idle burst first; hold until taken
	task automatic send_word(logic [7:0] d, logic s, logic [31:0] len);
		int gap;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		start_req <= s;
		buffer_length <= len;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_words++;
		void'(decode_obu_byte(d, s, len));
	endtask

	// Drop the input and hold until every expected word has come out
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_headers.size() != 0) @(posedge clk);
	endtask

	// Receiver stall: long holds on request, else random bursts
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				out_stall <= 1'b1;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
				out_stall <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Compare each accepted result with the oldest expected header
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_headers.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual status %0d",
					$time, status);
				mismatches++;
			end else begin
				want = expected_headers.pop_front();
				check_field("status", want.status, status);
				check_field("obu_kind", want.obu_kind, obu_kind);
				check_field("has_extension", want.has_extension, has_extension);
				check_field("tlayer_id", want.tlayer_id, tlayer_id);
				check_field("slayer_id", want.slayer_id, slayer_id);
				check_field("header_length", want.header_length, header_length);
				check_field("payload_size", want.payload_size, payload_size);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic test_empty_and_idle();
		send_word(8'hFF, SAME_BUF, 32'hFFFF_FFFF);
		send_word(8'hFF, NEW_BUF, 32'd0);
		send_word(8'h00, NEW_BUF, 32'd0);
		wait_for_results();
	endtask

	task automatic test_bad_type();
		send_word(hdr_byte(OBU_RESERVED_0, 1'b0, 1'b0), NEW_BUF, 32'd5);
		send_word(hdr_byte(OBU_RESERVED_9, 1'b1, 1'b1), NEW_BUF, 32'hFFFF_FFFF);
		wait_for_results();
	endtask

	task automatic test_missing_extension();
		send_word(hdr_byte(OBU_SEQ_HDR, 1'b1, 1'b0), NEW_BUF, 32'd1);
		wait_for_results();
	endtask

	task automatic test_truncated_size();
		// size field would start past the end
		send_word(hdr_byte(OBU_FRAME, 1'b0, 1'b1), NEW_BUF, 32'd1);
		send_word(hdr_byte(OBU_FRAME, 1'b1, 1'b1), NEW_BUF, 32'd2);
		send_word(8'hA8, SAME_BUF, 32'd0);
		// continuation on the last word of the buffer
		send_word(hdr_byte(OBU_FRAME, 1'b0, 1'b1), NEW_BUF, 32'd2);
		send_word(8'h80, SAME_BUF, 32'd0);
		wait_for_results();
	endtask

	task automatic test_plain_headers();
		send_word(hdr_byte(OBU_TD, 1'b0, 1'b0) | 8'h81, NEW_BUF, 32'hFFFF_FFFF);
		send_word(hdr_byte(OBU_PADDING, 1'b1, 1'b0), NEW_BUF, 32'd2);
		send_word(8'hF8, SAME_BUF, 32'hFFFF_FFFF);
		send_word(8'hFF, NEW_BUF, 32'hFFFF_FFFF);
		send_word(8'hFF, SAME_BUF, 32'd0);
		send_word(8'h00, SAME_BUF, 32'd0);
		wait_for_results();
	endtask

	task automatic test_size_field();
		// 0xFFFFFFFF overflows
		send_word(hdr_byte(OBU_FRAME, 1'b0, 1'b1), NEW_BUF, 32'hFFFF_FFFF);
		repeat (4) send_word(8'hFF, SAME_BUF, 32'd0);
		send_word(8'h0F, SAME_BUF, 32'd0);
		// eight groups end the size even with continuation set
		send_word(hdr_byte(OBU_FRAME, 1'b0, 1'b1), NEW_BUF, 32'd20);
		send_word(8'h81, SAME_BUF, 32'd0);
		repeat (7) send_word(8'h80, SAME_BUF, 32'd0);
		// size larger than what is left of the buffer
		send_word(hdr_byte(OBU_FRAME, 1'b0, 1'b1), NEW_BUF, 32'd3);
		send_word(8'h05, SAME_BUF, 32'd0);
		wait_for_results();
	endtask

	task automatic test_restart();
		send_word(hdr_byte(OBU_FRAME, 1'b1, 1'b1), NEW_BUF, 32'd10);
		send_word(8'h48, SAME_BUF, 32'd0);
		send_word(8'h85, SAME_BUF, 32'd0);
		send_word(hdr_byte(OBU_TD, 1'b0, 1'b0), NEW_BUF, 32'd1);
		wait_for_results();
	endtask

	// One buffer, mostly well formed, with random content and length
	task automatic random_buffer();
		logic [7:0]  words[$];
		logic [3:0]  t;
		logic        ext;
		logic        sf;
		logic [63:0] v;
		logic [31:0] len;
		int          groups;
		int          hlen;
		int          cut;
		v = '0;
		t = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 9) != 0)
			while (!LEGAL_TYPES[t]) t = 4'($urandom_range(0, 15));
		ext = 1'($urandom_range(0, 1));
		sf = ($urandom_range(0, 3) != 0);
		words.push_back({1'($urandom_range(0, 1)), t, ext, sf, 1'($urandom_range(0, 1))});
		if (ext)
			words.push_back(8'($urandom_range(0, 255)));
		if (sf) begin
			if ($urandom_range(0, 9) == 0) begin
				// raw groups: may overflow or run all eight
				groups = $urandom_range(1, SIZE_GROUPS_MAX);
				repeat (groups) words.push_back(8'($urandom));
			end else begin
				case ($urandom_range(0, 4))
					0, 1: v = $urandom_range(0, 200);
					2: v = $urandom_range(0, 70000);
					3: v = {32'b0, $urandom};
					default: v = 64'hFFFF_FFFE + $urandom_range(0, 1);
				endcase
				groups = 1;
				while ((v >> (7 * groups)) != 0) groups++;
				// sometimes pad with extra zero groups
				if ($urandom_range(0, 5) == 0)
					groups += $urandom_range(1, 3);
				if (groups > SIZE_GROUPS_MAX)
					groups = SIZE_GROUPS_MAX;
				for (int i = 0; i < groups; i++)
					words.push_back({1'(i < groups - 1), 7'(v >> (7 * i))});
			end
		end
		hlen = words.size();
		case ($urandom_range(0, 7))
			0, 1, 2, 3: len = 32'(hlen + v);
			4: len = 32'(hlen + v - 1);
			5: len = $urandom_range(0, hlen);
			6: len = $urandom;
			default: len = 32'(hlen + v + $urandom_range(1, 100));
		endcase
		// sometimes cut the buffer short so the next start restarts it
		cut = hlen;
		if ($urandom_range(0, 11) == 0)
			cut = $urandom_range(1, hlen);
		for (int i = 0; i < cut; i++)
			send_word(words[i], (i == 0), (i == 0) ? len : $urandom);
		repeat ($urandom_range(0, 2)) send_word(8'($urandom), SAME_BUF, $urandom);
	endtask

	task automatic test_random_buffers(int target);
		int first;
		first = sent_words;
		while (sent_words - first < target) begin
			if ($urandom_range(0, 9) == 0)
				send_word(8'($urandom), 1'($urandom_range(0, 1)), $urandom);
			else
				random_buffer();
		end
		wait_for_results();
	endtask

	// Hold the output while single-word headers keep coming
	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		rx_hold = 60;
		repeat (12)
			send_word(hdr_byte(OBU_TD, 1'b0, 1'b0), NEW_BUF, $urandom_range(1, 1000));
		wait_for_results();
		tx_idle_en = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= '0;
		start_req <= 1'b0;
		buffer_length <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_idle();
		test_bad_type();
		test_missing_extension();
		test_truncated_size();
		test_plain_headers();
		test_size_field();
		test_restart();
		test_random_buffers(650);
		test_backpressure();
		test_random_buffers(100);
		// no idling on either side to the end
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random_buffers(150);

		wait_for_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

[files.f]
src/obuhp_pkg.sv
src/obuhp_core.sv
src/av1_obu_header_parser_unit.sv
src/obuhp_checker.sv
tb/testbench.sv
